// File: design/spgf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segmented prime gap finder package
// Shared field widths, default sizes and result status codes.
// ----------------------------------------------------------------------------
package spgf_pkg;

  // Width of every bound and prime field.
  localparam int unsigned FIELD_W = 31;

  // Packed widths of the two stream buses.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 128;

  // Default window span and base prime limit.
  localparam int unsigned DEF_MAX_SPAN   = 65536;
  localparam int unsigned DEF_BASE_LIMIT = 46341;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_PAIRS = 2'd0,
    STATUS_FEW   = 2'd1,
    STATUS_SPAN  = 2'd2
  } status_e;

endpackage : spgf_pkg
`default_nettype wire

// File: design/spgf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spgf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : spgf_ram
`default_nettype wire

// File: design/spgf_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one dividend bit a cycle, returning only the remainder.
// ----------------------------------------------------------------------------
module spgf_mod_unit
  import spgf_pkg::*;
#(
  parameter int unsigned DIV_W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [FIELD_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0]   divisor_i,
  output logic                    done_o,
  output logic      [DIV_W-1:0]   rem_o
);

  localparam int unsigned CNT_W = $clog2(FIELD_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [FIELD_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]   div_q, div_d;
  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [DIV_W:0]     trial;
  logic               fits;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial  = {rem_q, dvd_q[FIELD_W-1]};
    fits   = trial >= (DIV_W + 1)'(div_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(FIELD_W - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[FIELD_W-2:0], 1'b0};
      rem_d = fits ? DIV_W'(trial - (DIV_W + 1)'(div_q)) : DIV_W'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule : spgf_mod_unit
`default_nettype wire

// File: design/spgf_gap_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prime gap tracker
// Follows surviving window offsets in order and keeps the first closest and
// the first most distant adjacent pair.
// ----------------------------------------------------------------------------
module spgf_gap_track #(
  parameter int unsigned IDX_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             hit_i,
  input  wire logic [IDX_W-1:0] idx_i,
  output logic                  have_pair_o,
  output logic      [IDX_W-1:0] c_lo_o,
  output logic      [IDX_W-1:0] c_hi_o,
  output logic      [IDX_W-1:0] d_lo_o,
  output logic      [IDX_W-1:0] d_hi_o
);

  logic             have_prev_q, have_prev_d;
  logic             have_pair_q, have_pair_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic [IDX_W-1:0] min_q, min_d, max_q, max_d;
  logic [IDX_W-1:0] c_lo_q, c_lo_d, c_hi_q, c_hi_d;
  logic [IDX_W-1:0] d_lo_q, d_lo_d, d_hi_q, d_hi_d;
  logic [IDX_W-1:0] gap;

  // Compare the new gap against the running extremes.
  always_comb begin
    gap         = idx_i - prev_q;
    have_prev_d = have_prev_q;
    have_pair_d = have_pair_q;
    prev_d      = prev_q;
    min_d       = min_q;
    max_d       = max_q;
    c_lo_d      = c_lo_q;
    c_hi_d      = c_hi_q;
    d_lo_d      = d_lo_q;
    d_hi_d      = d_hi_q;
    if (start_i) begin
      have_prev_d = 1'b0;
      have_pair_d = 1'b0;
    end else if (hit_i) begin
      if (have_prev_q) begin
        if (!have_pair_q) begin
          min_d       = gap;
          max_d       = gap;
          c_lo_d      = prev_q;
          c_hi_d      = idx_i;
          d_lo_d      = prev_q;
          d_hi_d      = idx_i;
          have_pair_d = 1'b1;
        end else begin
          if (gap > max_q) begin
            max_d  = gap;
            d_lo_d = prev_q;
            d_hi_d = idx_i;
          end
          if (gap < min_q) begin
            min_d  = gap;
            c_lo_d = prev_q;
            c_hi_d = idx_i;
          end
        end
      end
      prev_d      = idx_i;
      have_prev_d = 1'b1;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      have_pair_q <= 1'b0;
    end else begin
      have_prev_q <= have_prev_d;
      have_pair_q <= have_pair_d;
    end
  end

  // Pair and gap registers.
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    min_q  <= min_d;
    max_q  <= max_d;
    c_lo_q <= c_lo_d;
    c_hi_q <= c_hi_d;
    d_lo_q <= d_lo_d;
    d_hi_q <= d_hi_d;
  end

  assign have_pair_o = have_pair_q;
  assign c_lo_o      = c_lo_q;
  assign c_hi_o      = c_hi_q;
  assign d_lo_o      = d_lo_q;
  assign d_hi_o      = d_hi_q;

endmodule : spgf_gap_track
`default_nettype wire

// File: design/segmented_prime_gap_finder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segmented prime gap finder
// Sieves a query window against base primes and reports the first closest
// and the first most distant pair of adjacent primes in it.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         lower_bound, upper_bound (one query per request)
// m_axis    out        status, closest_low/high, distant_low/high
//
// After reset a boot sieve fills the base prime flag RAM: it sets every flag,
// then strikes the multiples of each base prime from its square; no query is
// taken meanwhile. A query sets the window to all ones, strikes the multiples
// of each base prime up to sqrt(upper) once a serial remainder has found the
// first one, and scans the window; the single window RAM port serves all three
// passes. A rejected query skips them. A result waits in the output register
// while the next query runs.
// ----------------------------------------------------------------------------
module segmented_prime_gap_finder_unit
  import spgf_pkg::*;
#(
  parameter int unsigned MAX_SPAN   = DEF_MAX_SPAN,
  parameter int unsigned BASE_LIMIT = DEF_BASE_LIMIT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // lower_bound [30:0], upper_bound [61:31], zero fill [63:62]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // status [1:0], closest_low [32:2], closest_high [63:33],
  // distant_low [94:64], distant_high [125:95], zero fill [127:126]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_SPAN);
  localparam int unsigned SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int unsigned P_W    = $clog2(BASE_LIMIT + 2);
  localparam int unsigned BF_AW  = $clog2(BASE_LIMIT + 1);
  localparam int unsigned CNT_W  = (SPAN_W > P_W) ? SPAN_W : P_W;
  localparam int unsigned OFF_W  = CNT_W + 1;
  localparam int unsigned SQ_W   = (2 * P_W > FIELD_W + 1) ? 2 * P_W : FIELD_W + 1;

  typedef enum logic [3:0] {
    S_BOOT_CLR,
    S_BOOT_NEXT,
    S_BOOT_CHK,
    S_BOOT_STRIKE,
    S_IDLE,
    S_CHECK,
    S_CLR,
    S_PNEXT,
    S_PCHK,
    S_PDIV,
    S_PSTRIKE,
    S_SCAN,
    S_SLAST,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   pend_q;

  logic [FIELD_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [SPAN_W-1:0]      span_q, span_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [P_W-1:0]         p_q, p_d;
  logic [SQ_W-1:0]        sq_q, sq_d;
  logic [OFF_W-1:0]       off_q, off_d;
  logic [OFF_W-1:0]       self_off_q, self_off_d;
  logic                   self_hit_q, self_hit_d;
  status_e                status_q, status_d;
  logic [IDX_W-1:0]       pend_idx_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic [FIELD_W-1:0] in_lo, in_hi, lo_raised;
  logic [FIELD_W:0]   span_wide;

  // Window RAM port signals.
  logic             win_we, win_wdata, win_rdata;
  logic [IDX_W-1:0] win_waddr, win_raddr;

  // Base prime flag RAM port signals.
  logic             bf_we, bf_wdata, bf_rdata;
  logic [BF_AW-1:0] bf_waddr, bf_raddr;

  // Remainder unit and gap tracker hook-up.
  logic             mod_start, mod_done;
  logic [P_W-1:0]   mod_rem;
  logic             trk_start;
  logic             have_pair;
  logic [IDX_W-1:0] c_lo_idx, c_hi_idx, d_lo_idx, d_hi_idx;
  status_e          final_status;

  assign in_lo     = s_axis_tdata_i[FIELD_W-1:0];
  assign in_hi     = s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
  assign lo_raised = (in_lo < FIELD_W'(2)) ? FIELD_W'(2) : in_lo;
  assign span_wide = {1'b0, hi_q} - {1'b0, lo_q} + (FIELD_W + 1)'(1);

  assign final_status = (status_q == STATUS_PAIRS && !have_pair) ? STATUS_FEW : status_q;

  // Sequencer next-state and datapath control.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    span_d      = span_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    sq_d        = sq_q;
    off_d       = off_q;
    self_off_d  = self_off_q;
    self_hit_d  = self_hit_q;
    status_d    = status_q;
    out_data_d  = out_data_q;
    win_we      = 1'b0;
    win_wdata   = 1'b1;
    win_waddr   = cnt_q[IDX_W-1:0];
    win_raddr   = cnt_q[IDX_W-1:0];
    bf_we       = 1'b0;
    bf_wdata    = 1'b1;
    bf_waddr    = cnt_q[BF_AW-1:0];
    bf_raddr    = p_q[BF_AW-1:0];
    mod_start   = 1'b0;
    trk_start   = 1'b0;

    // A waiting result leaves as soon as the sink takes it.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // Boot: mark every candidate as prime.
      S_BOOT_CLR: begin
        bf_we = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(BASE_LIMIT)) begin
          p_d     = P_W'(2);
          sq_d    = SQ_W'(4);
          state_d = S_BOOT_NEXT;
        end
      end
      // Boot: next sieving prime, or done once its square passes the limit.
      S_BOOT_NEXT: begin
        if (sq_q > SQ_W'(BASE_LIMIT)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_BOOT_CHK;
        end
      end
      S_BOOT_CHK: begin
        if (bf_rdata) begin
          off_d   = OFF_W'(sq_q);
          state_d = S_BOOT_STRIKE;
        end else begin
          sq_d    = sq_q + SQ_W'({p_q, 1'b1});
          p_d     = p_q + P_W'(1);
          state_d = S_BOOT_NEXT;
        end
      end
      // Boot: strike multiples from the square upwards.
      S_BOOT_STRIKE: begin
        if (off_q <= OFF_W'(BASE_LIMIT)) begin
          bf_we    = 1'b1;
          bf_wdata = 1'b0;
          bf_waddr = off_q[BF_AW-1:0];
          off_d    = off_q + OFF_W'(p_q);
        end else begin
          sq_d    = sq_q + SQ_W'({p_q, 1'b1});
          p_d     = p_q + P_W'(1);
          state_d = S_BOOT_NEXT;
        end
      end
      // Take a query; the lower bound is raised to two on entry.
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          lo_d    = lo_raised;
          hi_d    = in_hi;
          state_d = S_CHECK;
        end
      end
      // Reject empty and oversized ranges.
      S_CHECK: begin
        trk_start = 1'b1;
        cnt_d     = '0;
        span_d    = span_wide[SPAN_W-1:0];
        if (lo_q > hi_q) begin
          status_d = STATUS_FEW;
          state_d  = S_DONE;
        end else if (span_wide > (FIELD_W + 1)'(MAX_SPAN)) begin
          status_d = STATUS_SPAN;
          state_d  = S_DONE;
        end else begin
          status_d = STATUS_PAIRS;
          state_d  = S_CLR;
        end
      end
      // Set the window to all ones over the span.
      S_CLR: begin
        win_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q + CNT_W'(1) == CNT_W'(span_q)) begin
          p_d     = P_W'(2);
          sq_d    = SQ_W'(4);
          state_d = S_PNEXT;
        end
      end
      // Next base prime candidate while its square stays within the range.
      S_PNEXT: begin
        cnt_d = '0;
        if (p_q > P_W'(BASE_LIMIT) || sq_q > SQ_W'(hi_q)) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_PCHK;
        end
      end
      // Prime candidates start the remainder; the prime itself is spared.
      S_PCHK: begin
        self_hit_d = FIELD_W'(p_q) >= lo_q;
        self_off_d = OFF_W'(p_q) - OFF_W'(lo_q);
        if (bf_rdata) begin
          mod_start = 1'b1;
          state_d   = S_PDIV;
        end else begin
          sq_d    = sq_q + SQ_W'({p_q, 1'b1});
          p_d     = p_q + P_W'(1);
          state_d = S_PNEXT;
        end
      end
      // First multiple at or above the lower bound.
      S_PDIV: begin
        if (mod_done) begin
          off_d   = (mod_rem == '0) ? '0 : OFF_W'(p_q - mod_rem);
          state_d = S_PSTRIKE;
        end
      end
      // Strike multiples across the window.
      S_PSTRIKE: begin
        if (off_q < OFF_W'(span_q)) begin
          win_we    = !(self_hit_q && off_q == self_off_q);
          win_wdata = 1'b0;
          win_waddr = off_q[IDX_W-1:0];
          off_d     = off_q + OFF_W'(p_q);
        end else begin
          sq_d    = sq_q + SQ_W'({p_q, 1'b1});
          p_d     = p_q + P_W'(1);
          state_d = S_PNEXT;
        end
      end
      // Read the window in order; the tracker sees each bit in the cycle after its read.
      S_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q + CNT_W'(1) == CNT_W'(span_q)) begin
          state_d = S_SLAST;
        end
      end
      S_SLAST: begin
        state_d = S_DONE;
      end
      // Load the result once the output register is free.
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d = '0;
          out_data_d[1:0] = final_status;
          if (final_status == STATUS_PAIRS) begin
            out_data_d[FIELD_W+1:2]             = lo_q + FIELD_W'(c_lo_idx);
            out_data_d[2*FIELD_W+1:FIELD_W+2]   = lo_q + FIELD_W'(c_hi_idx);
            out_data_d[3*FIELD_W+1:2*FIELD_W+2] = lo_q + FIELD_W'(d_lo_idx);
            out_data_d[4*FIELD_W+1:3*FIELD_W+2] = lo_q + FIELD_W'(d_hi_idx);
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BOOT_CLR;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= (state_q == S_SCAN);
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    span_q     <= span_d;
    p_q        <= p_d;
    sq_q       <= sq_d;
    off_q      <= off_d;
    self_off_q <= self_off_d;
    self_hit_q <= self_hit_d;
    status_q   <= status_d;
    pend_idx_q <= cnt_q[IDX_W-1:0];
    out_data_q <= out_data_d;
  end

  // Query window bitmap.
  spgf_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SPAN)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  // Base prime flags, filled by the boot sieve.
  spgf_ram #(
    .WIDTH (1),
    .DEPTH (BASE_LIMIT + 1)
  ) u_base_ram (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (bf_wdata),
    .raddr_i (bf_raddr),
    .rdata_o (bf_rdata)
  );

  // Shared remainder unit for the first multiple of each prime.
  spgf_mod_unit #(
    .DIV_W (P_W)
  ) u_mod_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lo_q),
    .divisor_i  (p_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Adjacent pair tracking over the scan.
  spgf_gap_track #(
    .IDX_W (IDX_W)
  ) u_gap_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (trk_start),
    .hit_i       (pend_q && win_rdata),
    .idx_i       (pend_idx_q),
    .have_pair_o (have_pair),
    .c_lo_o      (c_lo_idx),
    .c_hi_o      (c_hi_idx),
    .d_lo_o      (d_lo_idx),
    .d_hi_o      (d_hi_idx)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule : segmented_prime_gap_finder_unit
`default_nettype wire

// File: verif/segmented_prime_gap_finder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segmented prime gap finder testbench
// Sends range queries over the input stream and predicts each result with its
// own window sieve. A checker compares every returned report field by field
// with the oldest pending prediction. Both streams idle at random. One test
// holds the result stream off until the block backs up onto its input.
// ----------------------------------------------------------------------------
module segmented_prime_gap_finder_unit_tb;
  import spgf_pkg::*;

  localparam int unsigned MAX_SPAN    = DEF_MAX_SPAN;
  localparam int unsigned BASE_LIMIT  = DEF_BASE_LIMIT;
  localparam int unsigned FIELD_MAX   = 32'h7FFF_FFFF;
  localparam int unsigned QUIET_LIMIT = 1_500_000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 4000;

  // One predicted report, tagged with the query that caused it.
  typedef struct {
    logic [FIELD_W-1:0] lower;
    logic [FIELD_W-1:0] upper;
    status_e            status;
    logic [FIELD_W-1:0] closest_low;
    logic [FIELD_W-1:0] closest_high;
    logic [FIELD_W-1:0] distant_low;
    logic [FIELD_W-1:0] distant_high;
  } gap_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  gap_report_t pending_gaps[$];
  int unsigned seed_primes[$];
  bit          composite_flags [BASE_LIMIT+1];
  bit          sieve_window [MAX_SPAN];
  int unsigned mismatch_count = 0;
  bit          no_idle = 1'b0;
  int unsigned hold_requests = 0;

  segmented_prime_gap_finder_unit #(
    .MAX_SPAN  (MAX_SPAN),
    .BASE_LIMIT(BASE_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sieves one query range and finds its first closest and first widest
  // adjacent prime pair.
  function automatic gap_report_t find_prime_gaps(input logic [FIELD_W-1:0] lower_in,
                                                  input logic [FIELD_W-1:0] upper_in);
    longint unsigned lo, hi, span, p, j, v, prev, gap, min_gap, max_gap;
    bit have_prev, have_pair;
    gap_report_t r;
    r.lower        = lower_in;
    r.upper        = upper_in;
    r.status       = STATUS_PAIRS;
    r.closest_low  = '0;
    r.closest_high = '0;
    r.distant_low  = '0;
    r.distant_high = '0;
    lo = lower_in;
    hi = upper_in;
    // Zero and one are never prime, so the range starts at two at the earliest.
    if (lo < 2) lo = 2;
    if (lo > hi) begin
      r.status = STATUS_FEW;
      return r;
    end
    span = hi - lo + 1;
    if (span > MAX_SPAN) begin
      r.status = STATUS_SPAN;
      return r;
    end
    for (longint unsigned i = 0; i < span; i++) sieve_window[i] = 1'b1;
    // Strike multiples of every seed prime up to the square root of the top,
    // leaving the prime itself where it lies inside the range.
    for (int k = 0; k < seed_primes.size(); k++) begin
      p = seed_primes[k];
      if (p * p > hi) break;
      j = (lo % p == 0) ? lo : lo + (p - lo % p);
      while (j <= hi) begin
        if (j != p) sieve_window[j - lo] = 1'b0;
        j += p;
      end
    end
    // Walk the survivors in order; ties keep the earliest pair.
    prev      = 0;
    min_gap   = 0;
    max_gap   = 0;
    have_prev = 1'b0;
    have_pair = 1'b0;
    for (longint unsigned i = 0; i < span; i++) begin
      if (!sieve_window[i]) continue;
      v = lo + i;
      if (have_prev) begin
        gap = v - prev;
        if (!have_pair) begin
          min_gap        = gap;
          max_gap        = gap;
          r.closest_low  = prev[FIELD_W-1:0];
          r.closest_high = v[FIELD_W-1:0];
          r.distant_low  = prev[FIELD_W-1:0];
          r.distant_high = v[FIELD_W-1:0];
          have_pair      = 1'b1;
        end else begin
          if (gap > max_gap) begin
            max_gap        = gap;
            r.distant_low  = prev[FIELD_W-1:0];
            r.distant_high = v[FIELD_W-1:0];
          end
          if (gap < min_gap) begin
            min_gap        = gap;
            r.closest_low  = prev[FIELD_W-1:0];
            r.closest_high = v[FIELD_W-1:0];
          end
        end
      end
      prev      = v;
      have_prev = 1'b1;
    end
    if (!have_pair) begin
      r.status       = STATUS_FEW;
      r.closest_low  = '0;
      r.closest_high = '0;
      r.distant_low  = '0;
      r.distant_high = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned seen);
    $display("ERROR at %0t: %s: expected %0d, got %0d", $realtime, what, want, seen);
    mismatch_count++;
  endtask

  // Offers one query, with a random idle gap first, and records its
  // prediction once the request is taken.
  task automatic offer_query(input logic [FIELD_W-1:0] lower, input logic [FIELD_W-1:0] upper);
    while (!no_idle && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b00, upper, lower};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_gaps.insert(pending_gaps.size(), find_prime_gaps(lower, upper));
  endtask

  // Stops offering and waits for every predicted report to come back.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (pending_gaps.size() != 0) @(posedge clk_i);
  endtask

  // Result stream ready: random stalls, or a long hold-off when a test asks.
  always @(posedge clk_i) begin : result_sink
    int unsigned hold_seen;
    int unsigned hold_left;
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  // Compares each returned report with the oldest prediction.
  always @(posedge clk_i) begin : report_checker
    gap_report_t want;
    string       tag;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_gaps.size() == 0) begin
        flag_mismatch("report with no query pending, status", 0, m_axis_tdata[1:0]);
      end else begin
        want = pending_gaps.pop_front();
        tag  = $sformatf("query [%0d, %0d]", want.lower, want.upper);
        if (m_axis_tdata[1:0] !== want.status)
          flag_mismatch({tag, " status"}, want.status, m_axis_tdata[1:0]);
        if (m_axis_tdata[32:2] !== want.closest_low)
          flag_mismatch({tag, " closest_low"}, want.closest_low, m_axis_tdata[32:2]);
        if (m_axis_tdata[63:33] !== want.closest_high)
          flag_mismatch({tag, " closest_high"}, want.closest_high, m_axis_tdata[63:33]);
        if (m_axis_tdata[94:64] !== want.distant_low)
          flag_mismatch({tag, " distant_low"}, want.distant_low, m_axis_tdata[94:64]);
        if (m_axis_tdata[125:95] !== want.distant_high)
          flag_mismatch({tag, " distant_high"}, want.distant_high, m_axis_tdata[125:95]);
      end
    end
  end

  // Ends the run when no request moves on either stream for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("TIMEOUT: no request accepted for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Field extremes, bound raising, empty and oversized ranges, ties.
  task automatic test_directed_ranges();
    offer_query(31'd1, 31'd1);
    offer_query(31'd1, 31'd2);
    offer_query(31'd1, 31'd3);
    offer_query(31'd2, 31'd30);
    offer_query(31'd3, 31'd20);
    offer_query(31'd1, 31'd100);
    offer_query(31'd25, 31'd50);
    offer_query(31'd24, 31'd28);
    offer_query(31'd90, 31'd96);
    offer_query(31'd89, 31'd97);
    offer_query(31'd10, 31'd5);
    offer_query(31'h7FFF_FFFF, 31'd1);
    offer_query(31'd1, 31'h7FFF_FFFF);
    offer_query(31'd1, 31'(MAX_SPAN + 2));
    offer_query(31'd1, 31'(MAX_SPAN + 1));
    offer_query(31'd2, 31'(MAX_SPAN + 2));
    offer_query(31'd2147483600, 31'h7FFF_FFFF);
    drain_reports();
  endtask

  // Holds the result stream off while small queries keep coming, so the
  // block backs up and stalls its input.
  task automatic test_result_backpressure();
    int unsigned lo;
    hold_requests++;
    for (int n = 0; n < 8; n++) begin
      lo = $urandom_range(2000, 1);
      offer_query(31'(lo), 31'(lo + $urandom_range(16, 0)));
    end
    drain_reports();
  endtask

  // Mostly small well-formed ranges, with rejected queries and a few ranges
  // high enough to need many seed primes.
  task automatic test_random_queries();
    int unsigned kind, lo, hi, width;
    no_idle = 1'b1;
    for (int n = 0; n < 75; n++) begin
      if (n == 30) no_idle = 1'b0;
      kind = $urandom_range(99);
      if (kind < 4) begin
        lo = $urandom_range(FIELD_MAX, 2);
        hi = $urandom_range(lo - 1, 1);
      end else if (kind < 8) begin
        lo = $urandom_range(FIELD_MAX - MAX_SPAN, 2);
        hi = $urandom_range(FIELD_MAX, lo + MAX_SPAN);
      end else if (kind < 11) begin
        hi = $urandom_range(1 << 24, 1 << 20);
        lo = hi - $urandom_range(63, 0);
      end else if (kind < 20) begin
        lo = 1;
        hi = $urandom_range(128, 1);
      end else begin
        hi    = $urandom_range(16384, 1);
        width = $urandom_range(120, 0);
        lo    = (hi > width) ? hi - width : 1;
      end
      offer_query(31'(lo), 31'(hi));
    end
    drain_reports();
  endtask

  initial begin : main
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    // Seed primes up to the base limit, built once at the start.
    for (int unsigned n = 2; n <= BASE_LIMIT; n++) begin
      if (!composite_flags[n]) begin
        seed_primes.insert(seed_primes.size(), n);
        for (int unsigned m = n * n; m <= BASE_LIMIT; m += n) composite_flags[m] = 1'b1;
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ranges();
    test_result_backpressure();
    test_random_queries();

    // Allow a late stray report to show up before deciding.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_gaps.size() != 0)
      flag_mismatch("reports never returned", 0, pending_gaps.size());
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/spgf_pkg.sv
design/spgf_ram.sv
design/spgf_mod_unit.sv
design/spgf_gap_track.sv
design/segmented_prime_gap_finder_unit.sv
verif/segmented_prime_gap_finder_unit_tb.sv
